### rtl/fir_pkg.sv
package fir_pkg;

   localparam int RATIO       = 8;
   localparam int TAPS        = 365;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int COEF_FRAC   = 16;
   localparam int HALF_LEN    = 183;
   localparam int FULL_LEN    = 2 * HALF_LEN - 1;

   // first half of the symmetric low-pass, taps 0..182, Q1.16
   localparam logic signed [17:0] HALF_COEFS [0:HALF_LEN-1] = '{
      13, 19, 22, 22, 19, 11, 0, -13,
      -25, -35, -41, -40, -33, -19, 0, 21,
      42, 57, 66, 64, 52, 30, 0, -33,
      -64, -87, -99, -96, -77, -44, 0, 48,
      92, 126, 142, 137, 110, 62, 0, -67,
      -129, -175, -197, -189, -151, -85, 0, 91,
      175, 237, 265, 254, 201, 113, 0, -121,
      -231, -312, -350, -334, -264, -148, 0, 157,
      300, 405, 452, 431, 340, 190, 0, -202,
      -384, -516, -576, -548, -432, -240, 0, 255,
      484, 651, 725, 688, 542, 301, 0, -319,
      -605, -812, -903, -857, -674, -375, 0, 395,
      750, 1006, 1118, 1061, 833, 463, 0, -488,
      -925, -1241, -1378, -1307, -1026, -570, 0, 600,
      1139, 1527, 1696, 1608, 1263, 702, 0, -739,
      -1402, -1881, -2090, -1983, -1559, -866, 0, 914,
      1736, 2331, 2593, 2463, 1939, 1079, 0, -1142,
      -2173, -2923, -3259, -3102, -2447, -1366, 0, 1454,
      2774, 3745, 4190, 4004, 3172, 1778, 0, -1912,
      -3667, -4980, -5608, -5396, -4306, -2433, 0, 2665,
      5166, 7095, 8089, 7891, 6393, 3674, 0, -4184,
      -8302, -11706, -13753, -13886, -11710, -7052, 0, 9089,
      19613, 30777, 41670, 51358, 58985, 63860, 65536
   };

   // coefficient lookup with mirroring and zero beyond the filter
   function automatic logic signed [17:0] coef_at(input logic [10:0] j);
      logic [10:0] m;
      begin
         m = j;
         if (j >= 11'(FULL_LEN)) begin
            coef_at = '0;
         end else begin
            if (j >= 11'(HALF_LEN)) begin
               m = 11'(FULL_LEN - 1) - j;
            end
            coef_at = HALF_COEFS[m[7:0]];
         end
      end
   endfunction

   typedef struct packed {
      logic clear;
      logic enable;
   } mac_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MAC  = 4'b0010,
      ST_LAST = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

endpackage

### rtl/fir_mac.sv
module fir_mac #(
   parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS,
   parameter int COEF_BITS   = fir_pkg::COEF_BITS,
   parameter int ACC_BITS    = 48
) (
   input  logic                          clock,
   input  fir_pkg::mac_ctrl_type         ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [COEF_BITS-1:0]   coef,
   output logic signed [ACC_BITS-1:0]    acc
);

   logic signed [SAMPLE_BITS+COEF_BITS-1:0] prod_ff;
   logic                                    pvld_ff;
   logic signed [ACC_BITS-1:0]              acc_ff;
   logic signed [ACC_BITS-1:0]              acc_in;

   // register the product, then accumulate
   always_ff @(posedge clock) begin
      prod_ff <= sample * coef;
      pvld_ff <= ctrl.enable;
      acc_ff  <= acc_in;
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (pvld_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   assign acc = acc_ff;

endmodule

### rtl/fir_interpolator_x8.sv
// Per input, RATIO passes over the delay line, one per output phase, each followed by an
//   output transfer that waits for rsp_tready; one shared multiply-accumulate unit does all
//   passes, so a new input is taken only in idle, once the last phase of the previous input
//   has been transferred.
// Reset: synchronous, active high; clears the delay line valid flags, the write pointer and control.
module fir_interpolator_x8 #(
   parameter int RATIO       = fir_pkg::RATIO,
   parameter int TAPS        = fir_pkg::TAPS,
   parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS,
   parameter int COEF_BITS   = fir_pkg::COEF_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] req_tdata,  // [SAMPLE_BITS-1:0] sample_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [SAMPLE_BITS-1:0] rsp_tdata,  // [SAMPLE_BITS-1:0] sample_out
   output logic [2:0]             rsp_tuser,  // [2:0] phase
   output logic                   rsp_tlast   // last
);

   localparam int DEPTH    = (TAPS + RATIO - 1) / RATIO;
   localparam int PW       = $clog2(DEPTH);
   localparam int KW       = $clog2(DEPTH + 1);
   localparam int RW       = $clog2(RATIO);
   localparam int ACC_BITS = SAMPLE_BITS + COEF_BITS + 12;
   localparam int FRAC     = fir_pkg::COEF_FRAC;

   fir_pkg::state_type state_ff, state_in;
   logic [SAMPLE_BITS-1:0] hist_mem [0:DEPTH-1];
   logic [DEPTH-1:0]       hvld_ff;
   logic [PW-1:0]          wptr_ff, newest_ff;
   logic [KW-1:0]          k_ff;
   logic [RW-1:0]          ph_ff;
   logic [PW-1:0]          ridx;
   logic signed [SAMPLE_BITS-1:0] hsamp_ff;
   logic signed [COEF_BITS-1:0]   coef_ff;
   logic                   fetch_ff;
   logic [1:0]             drain_ff;
   logic [10:0]            j;
   fir_pkg::mac_ctrl_type  ctrl;
   logic signed [ACC_BITS-1:0] acc;
   logic signed [ACC_BITS-1:0] rnd;
   logic signed [ACC_BITS-FRAC-1:0] q;
   logic [SAMPLE_BITS-1:0] sat;
   logic [SAMPLE_BITS-1:0] out_ff;

   assign j = 11'(k_ff) * 11'(RATIO) + 11'(ph_ff);

   // read index walks backward from the newest sample
   always_comb begin
      if (k_ff[PW-1:0] > newest_ff) begin
         ridx = PW'(newest_ff + PW'(DEPTH) - k_ff[PW-1:0]);
      end else begin
         ridx = newest_ff - k_ff[PW-1:0];
      end
   end

   // delay line with write and registered read
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hist_mem[wptr_ff] <= req_tdata;
      end
      hsamp_ff <= hvld_ff[ridx] ? hist_mem[ridx] : '0;
      coef_ff  <= COEF_BITS'(fir_pkg::coef_at(j));
      fetch_ff <= (state_ff == fir_pkg::ST_MAC) && (j < 11'(TAPS));
   end

   assign ctrl.clear  = (state_ff == fir_pkg::ST_IDLE) || (state_ff == fir_pkg::ST_OUT);
   assign ctrl.enable = fetch_ff;

   fir_mac #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEF_BITS  (COEF_BITS),
      .ACC_BITS   (ACC_BITS)
   ) u_mac (
      .clock (clock),
      .ctrl  (ctrl),
      .sample(hsamp_ff),
      .coef  (coef_ff),
      .acc   (acc)
   );

   // round half up, then clamp
   always_comb begin
      rnd = acc + ACC_BITS'(1 << (FRAC - 1));
      q   = rnd[ACC_BITS-1:FRAC];
      if (q > (ACC_BITS-FRAC)'((1 << (SAMPLE_BITS - 1)) - 1)) begin
         sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else if (q < -(ACC_BITS-FRAC)'(1 << (SAMPLE_BITS - 1))) begin
         sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         sat = q[SAMPLE_BITS-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fir_pkg::ST_IDLE: if (req_tvalid) state_in = fir_pkg::ST_MAC;
         fir_pkg::ST_MAC:  if (k_ff == KW'(DEPTH - 1)) state_in = fir_pkg::ST_LAST;
         fir_pkg::ST_LAST: if (drain_ff == 2'd3) state_in = fir_pkg::ST_OUT;
         fir_pkg::ST_OUT: begin
            if (rsp_tready) begin
               state_in = (ph_ff == RW'(RATIO - 1)) ? fir_pkg::ST_IDLE : fir_pkg::ST_MAC;
            end
         end
         default: state_in = fir_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fir_pkg::ST_IDLE;
         hvld_ff  <= '0;
         wptr_ff  <= '0;
         newest_ff <= '0;
         k_ff     <= '0;
         ph_ff    <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            fir_pkg::ST_IDLE: begin
               k_ff  <= '0;
               ph_ff <= '0;
               if (req_tvalid) begin
                  hvld_ff[wptr_ff] <= 1'b1;
                  newest_ff <= wptr_ff;
                  wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
               end
            end
            fir_pkg::ST_MAC: begin
               k_ff     <= k_ff + KW'(1);
               drain_ff <= '0;
            end
            fir_pkg::ST_LAST: drain_ff <= drain_ff + 2'd1;
            fir_pkg::ST_OUT: begin
               k_ff <= '0;
               if (rsp_tready) ph_ff <= ph_ff + RW'(1);
            end
            default: k_ff <= '0;
         endcase
      end
   end

   // hold the result while it is offered
   always_ff @(posedge clock) begin
      if (state_ff == fir_pkg::ST_LAST) begin
         out_ff <= sat;
      end
   end

   assign req_tready = (state_ff == fir_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == fir_pkg::ST_OUT);
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = 3'(ph_ff);
   assign rsp_tlast  = (ph_ff == RW'(RATIO - 1));

endmodule
